// ===== sv/joint_velocity_pd_task_core_macros.svh =====
// ----------------------------------------------------------------------------
// Joint velocity PD core assertion macros
// Shorthand for the concurrent checks of the core. Both macros sample on the
// rising edge of clk and are disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef JOINT_VELOCITY_PD_TASK_CORE_MACROS_SVH
`define JOINT_VELOCITY_PD_TASK_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent (or after an explicit delay).
`define JVPD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define JVPD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> cons) \
		else $error(msg);

`endif

// ===== sv/jvpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Joint velocity PD package
// Shared constants, codes, stage structs and Q16.16 arithmetic helpers.
// ----------------------------------------------------------------------------
package jvpd_pkg;

	// Default configuration of the core.
	localparam int JVPD_JOINTS     = 32;
	localparam int JVPD_FIFO_DEPTH = 4;

	// Register reset values.
	localparam logic [31:0] JVPD_TIME_STEP_RST     = 32'd4294967;
	localparam logic [31:0] JVPD_INV_TIME_STEP_RST = 32'd65536000;
	localparam logic [31:0] JVPD_JOINT_MASK_RST    = 32'hFFFF_FFFF;

	// Saturation limits in the wide product domain.
	localparam logic signed [65:0] S32_MAX66 = 66'sd2147483647;
	localparam logic signed [65:0] S32_MIN66 = -66'sd2147483648;

	// Item kinds.
	typedef enum logic {
		REQ_SAMPLE = 1'b0,
		REQ_GAIN   = 1'b1
	} req_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_TIME_STEP     = 2'd0,
		CFG_INV_TIME_STEP = 2'd1,
		CFG_JOINT_MASK    = 2'd2
	} cfg_reg_t;

	// Sample entering the arithmetic pipeline, with its joint's stored state.
	typedef struct packed {
		logic              v;
		logic [4:0]        joint;
		logic signed [31:0] err;
		logic signed [31:0] prev;
		logic signed [31:0] integ;
		logic signed [31:0] kp;
		logic signed [31:0] kd;
	} samp_t;

	// Write-back of one joint's error state.
	typedef struct packed {
		logic              we;
		logic [4:0]        joint;
		logic signed [31:0] prev;
		logic signed [31:0] integ;
	} wb_t;

	// One result item.
	typedef struct packed {
		logic [4:0]        joint;
		logic signed [31:0] accel;
		logic signed [31:0] vel_err;
		logic signed [31:0] pos_err;
		logic              active;
		logic [4:0]        slot;
	} res_t;

	// Clamp a wide signed value to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > S32_MAX66) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < S32_MIN66) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'(v);
		end
		return r;
	endfunction

	// Signed 33 x 33 bit product.
	function automatic logic signed [65:0] mul33(input logic signed [32:0] a,
			input logic signed [32:0] b);
		logic signed [65:0] ax;
		logic signed [65:0] bx;
		ax = 66'(a);
		bx = 66'(b);
		return ax * bx;
	endfunction

	// Divide by 2^16, rounding to nearest with ties away from zero.
	function automatic logic signed [65:0] rnd16(input logic signed [65:0] p);
		logic signed [65:0] t;
		t = p + 66'sh8000 - $signed({65'd0, p[65]});
		return t >>> 16;
	endfunction

	// Divide by 2^32, rounding to nearest with ties away from zero.
	function automatic logic signed [65:0] rnd32(input logic signed [65:0] p);
		logic signed [65:0] t;
		t = p + 66'sh8000_0000 - $signed({65'd0, p[65]});
		return t >>> 32;
	endfunction

	// Number of set mask bits below bit j, counted by nibbles then summed.
	function automatic logic [4:0] count_below(input logic [31:0] mask,
			input logic [4:0] j);
		logic [31:0] m;
		logic [2:0]  nib [8];
		logic [5:0]  c;
		for (int i = 0; i < 32; i++) begin
			m[i] = mask[i] & (5'(i) < j);
		end
		for (int n = 0; n < 8; n++) begin
			nib[n] = 3'(m[4*n]) + 3'(m[4*n+1]) + 3'(m[4*n+2]) + 3'(m[4*n+3]);
		end
		c = '0;
		for (int n = 0; n < 8; n++) begin
			c = c + 6'(nib[n]);
		end
		return 5'(c);
	endfunction

endpackage

// ===== sv/joint_velocity_pd_task_core.sv =====
// ----------------------------------------------------------------------------
// Joint velocity PD core
// Per-joint velocity PD loop in Q16.16. Items arrive on the in channel: a gain
// write stores a joint's Kp and Kd and gives no result; a sample gives one
// result item on the out channel. Registers (dt, 1/dt, joint mask) are written
// through the cfg channel, which is always ready; the user must write them only
// while the core is idle (unchecked by the core). Each sample runs through
// stages 1 to 5, is queued and is offered on out from the next cycle. No item
// is accepted while stage 1 holds a sample, for the read-modify-write of the
// error memory (read on acceptance, write-back from stage 2, with a forwarding
// path for the following read); gain writes go one per cycle while in_ready is
// high. Reset: registers take their defaults and per-entry valid bits make
// every stored error and gain read as zero at once; no clearing pass is needed.
// Stall: up to FIFO_DEPTH results are held; in_ready drops while that many
// samples are outstanding. Joints at or beyond JOINTS are accepted and dropped.
// ----------------------------------------------------------------------------
`include "joint_velocity_pd_task_core_macros.svh"

module joint_velocity_pd_task_core
	import jvpd_pkg::*;
#(
	parameter int JOINTS     = JVPD_JOINTS,
	parameter int FIFO_DEPTH = JVPD_FIFO_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,

	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic [4:0]         joint_index,
	input  logic signed [31:0] ref_vel,
	input  logic signed [31:0] meas_vel,
	input  logic signed [31:0] kp_gain,
	input  logic signed [31:0] kd_gain,

	output logic               out_valid,
	input  logic               out_ready,
	output logic [4:0]         out_joint,
	output logic signed [31:0] accel_des,
	output logic signed [31:0] vel_error,
	output logic signed [31:0] pos_error,
	output logic               axis_active,
	output logic [4:0]         axis_slot
);

	localparam int AW   = (JOINTS > 1) ? $clog2(JOINTS) : 1;
	localparam int PNDW = $clog2(FIFO_DEPTH + 1);

	// Configuration registers.
	logic [31:0] time_step_q, inv_time_step_q, joint_mask_q;

	// Handshake decode.
	logic          in_acc, joint_ok, samp_start, gain_we, out_acc;
	logic [AW-1:0] addr, wb_addr;

	// Per-entry valid bits of both memories.
	logic [JOINTS-1:0] gain_vld_q, err_vld_q;

	// Memory read data.
	logic [63:0] gain_rdata, err_rdata;

	// Stage 1 registers.
	logic               v_s1;
	logic [4:0]         joint_s1;
	logic signed [31:0] err_s1;
	logic               gvld_s1, evld_s1, fwd_hit_s1;
	logic [63:0]        fwd_data_s1;

	logic [PNDW-1:0] pend_q;

	samp_t samp;
	wb_t   wb;
	logic  push;
	res_t  res, out_data;

	// Handshake and address decode.
	always_comb begin
		cfg_ready  = 1'b1;
		addr       = AW'(joint_index);
		wb_addr    = AW'(wb.joint);
		joint_ok   = ({2'b00, joint_index} < 7'(JOINTS));
		in_ready   = !v_s1 && (pend_q < PNDW'(FIFO_DEPTH));
		in_acc     = in_valid && in_ready;
		samp_start = in_acc && joint_ok && (req_type == REQ_SAMPLE);
		gain_we    = in_acc && joint_ok && (req_type == REQ_GAIN);
		out_acc    = out_valid && out_ready;
	end

	// Configuration register writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q     <= JVPD_TIME_STEP_RST;
			inv_time_step_q <= JVPD_INV_TIME_STEP_RST;
			joint_mask_q    <= JVPD_JOINT_MASK_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TIME_STEP:     time_step_q     <= cfg_data;
				CFG_INV_TIME_STEP: inv_time_step_q <= cfg_data;
				CFG_JOINT_MASK:    joint_mask_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Gain memory, written directly by gain write items.
	jvpd_ram #(
		.WIDTH(64),
		.DEPTH(JOINTS)
	) u_gain_ram (
		.clk   (clk),
		.we    (gain_we),
		.waddr (addr),
		.wdata ({kp_gain, kd_gain}),
		.raddr (addr),
		.rdata (gain_rdata)
	);

	// Error memory: previous error and integrated error of each joint.
	jvpd_ram #(
		.WIDTH(64),
		.DEPTH(JOINTS)
	) u_err_ram (
		.clk   (clk),
		.we    (wb.we),
		.waddr (wb_addr),
		.wdata ({wb.prev, wb.integ}),
		.raddr (addr),
		.rdata (err_rdata)
	);

	// Valid bits: an entry never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_vld_q <= '0;
			err_vld_q  <= '0;
		end else begin
			if (gain_we) begin
				gain_vld_q[addr] <= 1'b1;
			end
			if (wb.we) begin
				err_vld_q[wb_addr] <= 1'b1;
			end
		end
	end

	// Stage 1 control and outstanding result count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			pend_q <= '0;
		end else begin
			v_s1   <= samp_start;
			pend_q <= pend_q + PNDW'(samp_start) - PNDW'(out_acc);
		end
	end

	// Stage 1 payload; a write-back to the entry being read is forwarded.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			joint_s1    <= joint_index;
			err_s1      <= sat32(66'(ref_vel) - 66'(meas_vel));
			gvld_s1     <= gain_vld_q[addr];
			evld_s1     <= err_vld_q[addr];
			fwd_hit_s1  <= wb.we && (wb_addr == addr);
			fwd_data_s1 <= {wb.prev, wb.integ};
		end
	end

	// Select the stored state for the sample.
	always_comb begin
		samp.v     = v_s1;
		samp.joint = joint_s1;
		samp.err   = err_s1;
		if (fwd_hit_s1) begin
			samp.prev  = fwd_data_s1[63:32];
			samp.integ = fwd_data_s1[31:0];
		end else if (evld_s1) begin
			samp.prev  = err_rdata[63:32];
			samp.integ = err_rdata[31:0];
		end else begin
			samp.prev  = '0;
			samp.integ = '0;
		end
		samp.kp = gvld_s1 ? gain_rdata[63:32] : '0;
		samp.kd = gvld_s1 ? gain_rdata[31:0] : '0;
	end

	jvpd_datapath u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.time_step         (time_step_q),
		.inverse_time_step (inv_time_step_q),
		.joint_mask        (joint_mask_q),
		.samp              (samp),
		.wb                (wb),
		.push              (push),
		.res               (res)
	);

	jvpd_out_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always_comb begin
		out_joint   = out_data.joint;
		accel_des   = out_data.accel;
		vel_error   = out_data.vel_err;
		pos_error   = out_data.pos_err;
		axis_active = out_data.active;
		axis_slot   = out_data.slot;
	end

	// A sample holds stage 1 for one cycle only, so the next read meets the write-back.
	`JVPD_ASSERT_NXT(a_s1_single, v_s1, !v_s1, "stage 1 held a sample for two cycles")

	// Every accepted sample writes its own joint's state back from stage 2.
	`JVPD_ASSERT_IMP(a_wb_follows, samp_start, ##2 (wb.we && wb.joint == $past(joint_index, 2)), "write-back missing or to the wrong joint")

	// A result on offer is always counted as outstanding.
	`JVPD_ASSERT_IMP(a_pend_cover, out_valid, (pend_q != '0), "result offered with no outstanding sample")

endmodule

// ===== sv/jvpd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// A read and a write of the same entry in one cycle return the old contents.
// ----------------------------------------------------------------------------
module jvpd_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/jvpd_datapath.sv =====
// ----------------------------------------------------------------------------
// Joint velocity PD arithmetic pipeline
// Takes a sample with its joint's stored state and gains, returns the error
// state write-back from stage 2 and the result item from stage 5.
// ----------------------------------------------------------------------------
module jvpd_datapath
	import jvpd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] time_step,
	input  logic [31:0] inverse_time_step,
	input  logic [31:0] joint_mask,
	input  samp_t       samp,
	output wb_t         wb,
	output logic        push,
	output res_t        res
);

	// Stage valid flags.
	logic v_s2, v_s3, v_s4, v_s5;

	// Stage payload.
	logic [4:0]         joint_s2, joint_s3, joint_s4, joint_s5;
	logic signed [31:0] err_s2, err_s3, err_s4, err_s5;
	logic               active_s2, active_s3, active_s4, active_s5;
	logic [4:0]         slot_s2, slot_s3, slot_s4, slot_s5;
	logic signed [31:0] integ_s2;
	logic signed [31:0] kd_s2, kd_s3, kd_s4;
	logic signed [32:0] diff_s2;
	logic signed [63:0] mstep_s2;
	logic signed [63:0] mkp_s2, mkp_s3;
	logic signed [64:0] mder_s3;
	logic signed [31:0] pos_s3, pos_s4, pos_s5;
	logic signed [31:0] deriv_s4;
	logic signed [47:0] kpr_s4, kpr_s5;
	logic signed [63:0] mkd_s5;

	// Combinational results of each stage.
	logic signed [65:0] mstep_c, mkp_c, mder_c, mkd_c;
	logic signed [32:0] diff_c;
	logic signed [31:0] pos_c, deriv_c, acc_c;
	logic signed [47:0] kpr_c;
	logic               active_c;
	logic [4:0]         slot_c;

	// Stage 1: error times dt, Kp times error, error difference, mask lookup.
	always_comb begin
		mstep_c  = mul33(33'(samp.err), $signed({1'b0, time_step}));
		mkp_c    = mul33(33'(samp.kp), 33'(samp.err));
		diff_c   = 33'(samp.err) - 33'(samp.prev);
		active_c = joint_mask[samp.joint];
		slot_c   = count_below(joint_mask, samp.joint);
	end

	// Stage 2: integrate and scale the error difference by 1/dt.
	always_comb begin
		pos_c  = sat32(66'(integ_s2) + rnd32(66'(mstep_s2)));
		mder_c = mul33(diff_s2, $signed({1'b0, inverse_time_step}));
	end

	// The joint's new error state is written back from stage 2.
	always_comb begin
		wb.we    = v_s2;
		wb.joint = joint_s2;
		wb.prev  = err_s2;
		wb.integ = pos_c;
	end

	// Stage 3: round the derivative and the proportional term.
	always_comb begin
		deriv_c = sat32(rnd16(66'(mder_s3)));
		kpr_c   = 48'(rnd16(66'(mkp_s3)));
	end

	// Stage 4: Kd times derivative.
	always_comb begin
		mkd_c = mul33(33'(kd_s4), 33'(deriv_s4));
	end

	// Stage 5: sum of both terms, saturated.
	always_comb begin
		acc_c = sat32(66'(kpr_s5) + rnd16(66'(mkd_s5)));
	end

	always_comb begin
		push        = v_s5;
		res.joint   = joint_s5;
		res.accel   = acc_c;
		res.vel_err = err_s5;
		res.pos_err = pos_s5;
		res.active  = active_s5;
		res.slot    = slot_s5;
	end

	// Valid flags advance one stage per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s2 <= samp.v;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		joint_s2  <= samp.joint;
		err_s2    <= samp.err;
		integ_s2  <= samp.integ;
		kd_s2     <= samp.kd;
		diff_s2   <= diff_c;
		mstep_s2  <= 64'(mstep_c);
		mkp_s2    <= 64'(mkp_c);
		active_s2 <= active_c;
		slot_s2   <= slot_c;

		joint_s3  <= joint_s2;
		err_s3    <= err_s2;
		pos_s3    <= pos_c;
		kd_s3     <= kd_s2;
		mder_s3   <= 65'(mder_c);
		mkp_s3    <= mkp_s2;
		active_s3 <= active_s2;
		slot_s3   <= slot_s2;

		joint_s4  <= joint_s3;
		err_s4    <= err_s3;
		pos_s4    <= pos_s3;
		kd_s4     <= kd_s3;
		deriv_s4  <= deriv_c;
		kpr_s4    <= kpr_c;
		active_s4 <= active_s3;
		slot_s4   <= slot_s3;

		joint_s5  <= joint_s4;
		err_s5    <= err_s4;
		pos_s5    <= pos_s4;
		kpr_s5    <= kpr_s4;
		mkd_s5    <= 64'(mkd_c);
		active_s5 <= active_s4;
		slot_s5   <= slot_s4;
	end

endmodule

// ===== sv/jvpd_out_fifo.sv =====
// ----------------------------------------------------------------------------
// Joint velocity PD result queue
// Small register queue that holds finished result items while the receiver
// stalls. The producer never pushes into a full queue.
// ----------------------------------------------------------------------------
module jvpd_out_fifo
	import jvpd_pkg::*;
#(
	parameter int DEPTH = JVPD_FIFO_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_data,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	res_t          entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   cnt_q;
	logic          pop;

	always_comb begin
		out_valid = (cnt_q != '0);
		out_data  = entry_q[rd_ptr_q];
		pop       = out_valid && out_ready;
	end

	// Pointers wrap at the queue depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW + 1)'(push) - (PW + 1)'(pop);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
